// ----- rtl/bdlp_pkg.sv -----
// Shared types and constants for the button debounce / long-press block.
// No dependencies; imported by the channel interfaces and the top level.
package bdlp_pkg;

  localparam int PIN_W   = 6;
  localparam int HIST_W  = 8;
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int MASK_W  = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [HIST_W-1:0] HIST_PRESSED   = 8'b1000_0000;
  localparam logic [HIST_W-1:0] HIST_DOWN_EDGE = 8'b0111_1111;
  localparam logic [HIST_W-1:0] HIST_ALL       = 8'b1111_1111;

  localparam logic [DUR_W-1:0]  LONG_PRESS_RST = 16'd2000;
  localparam logic [DUR_W-1:0]  REPEAT_RST     = 16'd200;
  localparam logic [MASK_W-1:0] INVERT_RST     = {MASK_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_RELEASED = 2'd0,
    KIND_PRESSED  = 2'd1,
    KIND_HELD     = 2'd2
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_REPEAT     = 2'd1,
    CFG_INVERT     = 2'd2
  } cfg_index_t;

  // One pin's state as held in the per-pin memory.
  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [TIME_W-1:0] deadline;
    logic              armed;
  } pin_state_t;

endpackage

// ----- rtl/bdlp_ifs.sv -----
// Valid/ready channel interfaces for the sample input and the event output.
// Depends on bdlp_pkg for field widths.
interface bdlp_in_if import bdlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIN_W-1:0]  pin_index;
  logic              raw_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, pin_index, raw_level, now_ms, input ready);
  modport sink   (input valid, pin_index, raw_level, now_ms, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] event_pin;
  logic [1:0]       event_kind;

  modport source (output valid, event_pin, event_kind, input ready);
  modport sink   (input valid, event_pin, event_kind, output ready);
endinterface

// ----- rtl/button_debounce_long_press_top.sv -----
// Button debounce with long-press repeat: top level.
// Per-pin history and hold deadline in one synchronous memory; uses bdlp_pkg, bdlp_ifs.
//
// Usage:
//   in_ch  : one poll sample per transaction (pin_index, raw_level, now_ms).
//   out_ch : zero or one event per sample (event_pin, event_kind:
//            0 released, 1 pressed, 2 held repeat), in sample order.
//   cfg_*  : write long_press_ms (0), repeat_ms (1), invert_mask (2) while idle.
// Throughput: one sample per cycle while out_ch is not stalled. The per-pin memory
//   is read when a sample is taken and written back when it leaves the update
//   stage; a write to the same pin at that edge is forwarded to the following sample.
// Events pass the update stage registers and then the output register to out_ch.
// Reset (rst_n low, synchronous): registers return to their defaults and
//   every pin's state reads as cleared through per-entry valid bits; no
//   clearing pass, samples are taken from the first cycle after reset.
// Stall: while out_ch holds an event that is not taken, a sample that would
//   produce another event waits in the update stage and in_ch drops ready.
//   Samples on pins at or above PIN_COUNT are dropped without effect.
module button_debounce_long_press_top import bdlp_pkg::*; #(
  parameter int PIN_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bdlp_in_if.sink              in_ch,
  bdlp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_wdata
);

  localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // configuration
  logic [DUR_W-1:0]  long_press_r;
  logic [DUR_W-1:0]  repeat_r;
  logic [MASK_W-1:0] invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      repeat_r     <= REPEAT_RST;
      invert_r     <= INVERT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[DUR_W-1:0];
        CFG_REPEAT:     repeat_r     <= cfg_wdata[DUR_W-1:0];
        CFG_INVERT:     invert_r     <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // pipeline control
  logic              s1_valid_r;
  logic [PIN_W-1:0]  s1_pin_r;
  logic              s1_level_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_event;
  logic              s1_fire;
  logic              in_take;
  logic              out_valid_r;

  assign s1_fire  = s1_valid_r && (!s1_event || !out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || s1_fire);
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r   <= in_ch.pin_index;
      s1_level_r <= in_ch.raw_level;
      s1_now_r   <= in_ch.now_ms;
    end
  end

  // per-pin memory with valid bits
  pin_state_t           mem [PIN_COUNT];
  logic [PIN_COUNT-1:0] entry_vld_r;
  pin_state_t           rd_data_r;
  logic                 rd_vld_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  pin_state_t           wr_data;
  logic [AW-1:0]        rd_addr;

  assign rd_addr = in_ch.pin_index[AW-1:0];
  assign wr_addr = s1_pin_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (in_take) begin
        rd_vld_r <= entry_vld_r[rd_addr];
      end
      if (wr_en) begin
        entry_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // last write, forwarded to a sample whose read raced it
  logic       wb_valid_r;
  logic [AW-1:0] wb_addr_r;
  pin_state_t wb_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (wr_en) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr_r <= wr_addr;
      wb_data_r <= wr_data;
    end
  end

  // update stage
  pin_state_t        cur;
  logic              in_range;
  logic              sample;
  logic [HIST_W-1:0] hist;
  logic [TIME_W-1:0] since;
  event_kind_t       kind;

  always_comb begin
    in_range = ({26'd0, s1_pin_r} < PIN_COUNT);
    if (wb_valid_r && wb_addr_r == s1_pin_r[AW-1:0]) begin
      cur = wb_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
    sample  = invert_r[s1_pin_r] ^ s1_level_r;
    hist    = {cur.hist[HIST_W-2:0], sample} | (cur.hist & HIST_PRESSED);
    since   = s1_now_r - cur.deadline;
    wr_data = cur;
    wr_data.hist = hist;
    kind     = KIND_HELD;
    s1_event = 1'b0;
    priority if (hist == HIST_PRESSED) begin
      wr_data.hist  = '0;
      wr_data.armed = 1'b0;
      kind          = KIND_RELEASED;
      s1_event      = in_range;
    end else if (hist == HIST_DOWN_EDGE) begin
      wr_data.hist     = HIST_ALL;
      wr_data.deadline = s1_now_r + {16'd0, long_press_r};
      wr_data.armed    = 1'b1;
      kind             = KIND_PRESSED;
      s1_event         = in_range;
    end else if (cur.armed && !since[TIME_W-1]) begin
      wr_data.deadline = cur.deadline + {16'd0, repeat_r};
      kind             = KIND_HELD;
      s1_event         = in_range;
    end else begin
      s1_event = 1'b0;
    end
    wr_en = s1_fire && in_range;
  end

  // output register
  logic [PIN_W-1:0] out_pin_r;
  event_kind_t      out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_event) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_event) begin
      out_pin_r  <= s1_pin_r;
      out_kind_r <= kind;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_pin  = out_pin_r;
  assign out_ch.event_kind = out_kind_r;

endmodule

// ----- tb/sv/bdlp_event_checker.sv -----
`timescale 1ns / 1ps
// Event checker for the button debounce / long-press block: tracks configuration
// writes, predicts at most one event per sample and compares against the event channel.
// Depends on bdlp_pkg and the channel interfaces in bdlp_ifs.
module bdlp_event_checker import bdlp_pkg::*; #(
  parameter int PIN_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bdlp_in_if                   sample_mon,
  bdlp_out_if                  event_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_wdata,
  output int                   pending_events,
  output int                   mismatch_count
);

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    event_kind_t      kind;
  } pin_event_t;

  logic [DUR_W-1:0]  long_press_ms;
  logic [DUR_W-1:0]  repeat_ms;
  logic [MASK_W-1:0] invert_mask;

  logic [HIST_W-1:0] history  [PIN_COUNT];
  logic [TIME_W-1:0] deadline [PIN_COUNT];
  logic              armed    [PIN_COUNT];

  pin_event_t expected_events [$];
  int         errors = 0;

  always @(posedge clk) begin : track
    pin_event_t        want;
    logic [PIN_W-1:0]  pin;
    logic [HIST_W-1:0] hist;
    logic [TIME_W-1:0] elapsed;
    int                p;
    if (!rst_n) begin
      long_press_ms = LONG_PRESS_RST;
      repeat_ms     = REPEAT_RST;
      invert_mask   = INVERT_RST;
      for (p = 0; p < PIN_COUNT; p++) begin
        history[p]  = '0;
        deadline[p] = '0;
        armed[p]    = 1'b0;
      end
      expected_events.delete();
    end else begin
      // compare first: an event never stems from a sample taken at this edge
      if (event_mon.valid && event_mon.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: event_pin %0d event_kind %0d",
                 event_mon.event_pin, event_mon.event_kind);
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (event_mon.event_pin !== want.pin) begin
            $error("event_pin mismatch: expected %0d, actual %0d",
                   want.pin, event_mon.event_pin);
            errors++;
          end
          if (event_mon.event_kind !== want.kind) begin
            $error("event_kind mismatch: expected %0d, actual %0d",
                   want.kind, event_mon.event_kind);
            errors++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PRESS: long_press_ms = cfg_wdata[DUR_W-1:0];
          CFG_REPEAT:     repeat_ms     = cfg_wdata[DUR_W-1:0];
          CFG_INVERT:     invert_mask   = cfg_wdata;
          default: ;
        endcase
      end

      if (sample_mon.valid && sample_mon.ready && sample_mon.pin_index < PIN_COUNT) begin
        pin      = sample_mon.pin_index;
        want.pin = pin;
        // shift in the corrected level, keep the sticky pressed bit
        hist = {history[pin][HIST_W-2:0], invert_mask[pin] ^ sample_mon.raw_level}
               | (history[pin] & HIST_PRESSED);
        if (hist == HIST_PRESSED) begin
          history[pin] = '0;
          armed[pin]   = 1'b0;
          want.kind    = KIND_RELEASED;
          expected_events.push_back(want);
        end else if (hist == HIST_DOWN_EDGE) begin
          history[pin]  = HIST_ALL;
          deadline[pin] = sample_mon.now_ms + TIME_W'(long_press_ms);
          armed[pin]    = 1'b1;
          want.kind     = KIND_PRESSED;
          expected_events.push_back(want);
        end else begin
          history[pin] = hist;
          elapsed      = sample_mon.now_ms - deadline[pin];
          if (armed[pin] && !elapsed[TIME_W-1]) begin
            deadline[pin] = deadline[pin] + TIME_W'(repeat_ms);
            want.kind     = KIND_HELD;
            expected_events.push_back(want);
          end
        end
      end
    end
    pending_events <= expected_events.size();
    mismatch_count <= errors;
  end

endmodule

// ----- tb/sv/tb_button_debounce_long_press_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for button_debounce_long_press_top: directed and random
// poll samples over several register settings; checking sits in bdlp_event_checker.
// Depends on bdlp_pkg, bdlp_ifs, the block itself and the checker.
module tb_button_debounce_long_press_top import bdlp_pkg::*; ();

  localparam int PIN_COUNT       = 64;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_wdata;

  bdlp_in_if  sample_ch ();
  bdlp_out_if event_ch ();

  int                pending_events;
  int                mismatch_count;
  int                idle_cycles = 0;
  int                time_step_max = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  bit                src_steady = 1'b0;
  bit                sink_steady = 1'b0;
  bit                hold_off_req = 1'b0;

  always #5 clk = ~clk;

  button_debounce_long_press_top #(.PIN_COUNT(PIN_COUNT)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bdlp_event_checker #(.PIN_COUNT(PIN_COUNT)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_mon     (sample_ch),
    .event_mon      (event_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending_events (pending_events),
    .mismatch_count (mismatch_count)
  );

  // Watchdog: count cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Event receiver: random stalls, plus one long hold-off on request.
  initial begin
    event_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        event_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        event_ch.ready <= 1'b1;
      end else begin
        event_ch.ready <= sink_steady || ($urandom_range(99) >= 25);
      end
    end
  end

  task automatic send_sample(input logic [PIN_W-1:0] pin, input logic level);
    while (!src_steady && $urandom_range(99) < 25) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    clock_ms = clock_ms + $urandom_range(time_step_max);
    sample_ch.valid     <= 1'b1;
    sample_ch.pin_index <= pin;
    sample_ch.raw_level <= level;
    sample_ch.now_ms    <= clock_ms;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Drop valid, drain all expected events, then let in-flight samples settle.
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [DUR_W-1:0] long_ms, input logic [DUR_W-1:0] rep_ms,
                           input logic [MASK_W-1:0] inv);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= MASK_W'(long_ms);
    @(posedge clk);
    cfg_index <= CFG_REPEAT;
    cfg_wdata <= MASK_W'(rep_ms);
    @(posedge clk);
    cfg_index <= CFG_INVERT;
    cfg_wdata <= inv;
    @(posedge clk);
    // unmapped index: must leave every register alone
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly steady bursts long enough to debounce, with glitches and short noise.
  task automatic run_random(input int n_items);
    int               sent;
    int               len;
    logic [PIN_W-1:0] pin;
    logic             level;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 5) clock_ms = $urandom;
      pin   = ($urandom_range(99) < 60) ? PIN_W'($urandom_range(3)) : PIN_W'($urandom_range(63));
      level = 1'($urandom_range(1));
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(7, 12);
        repeat (len) send_sample(pin, ($urandom_range(99) < 8) ? !level : level);
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_sample(PIN_W'($urandom_range(63)), 1'($urandom_range(1)));
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_LONG_PRESS;
    cfg_wdata           <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.pin_index <= '0;
    sample_ch.raw_level <= 1'b0;
    sample_ch.now_ms    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: press, deadline boundary, release, wrap on pin 63.
    repeat (7) send_sample(6'd0, 1'b0);
    clock_ms = 32'd1999;
    send_sample(6'd0, 1'b0);
    clock_ms = 32'd2000;
    send_sample(6'd0, 1'b0);
    clock_ms = 32'hFFFF_FFFF;
    send_sample(6'd0, 1'b0);
    repeat (7) send_sample(6'd0, 1'b1);
    clock_ms = 32'hFFFF_FF00;
    repeat (7) send_sample(6'd63, 1'b0);
    clock_ms = 32'h0000_06D0;
    send_sample(6'd63, 1'b1);

    configure(16'd1, 16'd1, {$urandom, $urandom});
    time_step_max = 3;
    run_random(100);

    // zero durations, and a stretch with no idling on either side
    configure(16'd0, 16'd0, '0);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    time_step_max = 2;
    run_random(100);
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    configure(16'hFFFF, 16'hFFFF, {MASK_W{1'b1}});
    time_step_max = 40000;
    run_random(100);

    configure(DUR_W'($urandom_range(1, 3000)), DUR_W'($urandom_range(1, 500)),
              {$urandom, $urandom});
    time_step_max = 600;
    run_random(100);

    // Pressure: pin 5 held with zero durations fires on every sample while
    // the receiver holds off, so the block fills and stalls its input.
    configure(16'd0, 16'd0, INVERT_RST);
    time_step_max = 3;
    repeat (8) send_sample(6'd5, 1'b1);
    repeat (7) send_sample(6'd5, 1'b0);
    hold_off_req = 1'b1;
    repeat (40) send_sample(6'd5, 1'b0);
    run_random(70);

    configure(DUR_W'($urandom_range(1, 50)), DUR_W'($urandom_range(1, 20)),
              {$urandom, $urandom});
    time_step_max = 10;
    run_random(100);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
